FILE: rtl/core/bse_pkg.sv
// Shared constants and types for the battery state-of-charge estimator.
package bse_pkg;

   localparam int MAX_POINTS = 16;
   localparam int ADC_BITS   = 12;
   localparam int PTR_W      = $clog2(MAX_POINTS);

   // Field widths fixed by the interface.
   localparam int MV_W    = 16;
   localparam int PCT_W   = 7;
   localparam int SOC_W   = 15;
   localparam int SUM_W   = 20;
   localparam int GAIN_W  = 32;
   localparam int PROD_W  = SUM_W + GAIN_W;
   localparam int DIVN_W  = PROD_W - 16;
   localparam int DIVD_W  = 16;
   localparam int CSR_W   = 32;
   localparam int CSR_A_W = 2;

   localparam logic [SOC_W-1:0] SOC_FULL = 15'd25600;
   localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

   // Configuration register indexes.
   localparam logic [CSR_A_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_GAIN         = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_LOW_LIMIT    = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_POINTS       = 2'd3;

   // One voltage to percent table point.
   typedef struct packed {
      logic [MV_W-1:0]  mv;
      logic [PCT_W-1:0] pct;
   } tab_entry_type;

endpackage

FILE: rtl/core/battery_soc_estimator.sv
// Top level of the battery state-of-charge estimator.
// The req_ channel carries either an ADC sample (mode 0) or a table point
// write (mode 1). Table writes and all samples but the last of a measurement
// are taken while idle and give no rsp_ transfer. The first sample of each
// measurement is discarded, the next sample_count are summed (a count of zero
// acts as one). The last sample starts the conversion: a multiply, a serial
// divide with a 36-bit quotient for the millivolt value, a walk over the table
// memory and, when interpolating, a second serial divide. The conversion time
// is set by the one-bit-per-cycle divider and the one read port of the table
// memory. Until the result register is loaded, req_ready is low.
// The result waits in the rsp_ output register until it is taken; a stalled
// receiver holds the block in its final state only once a next result is
// ready, and table writes and samples are still taken meanwhile.
// Reset restores the register defaults and starts a fresh measurement; the
// table is not cleared and must be written before use. The csr_ port writes
// one register per cycle and must only be used while the block is idle.
module battery_soc_estimator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic [11:0]                  req_adc_code,
   input  logic [3:0]                   req_point_index,
   input  logic [bse_pkg::MV_W-1:0]     req_point_millivolts,
   input  logic [bse_pkg::PCT_W-1:0]    req_point_percent,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bse_pkg::MV_W-1:0]     rsp_battery_millivolts,
   output logic [bse_pkg::SOC_W-1:0]    rsp_soc_q8,
   output logic                         rsp_battery_low,
   input  logic                         csr_we,
   input  logic [bse_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [bse_pkg::CSR_W-1:0]    csr_wdata
);
   import bse_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_DIV_MV, S_WAIT_MV, S_TAB_FIRST, S_TAB_LAST,
      S_TAB_END, S_TAB_PAIR, S_INTERP, S_WAIT_SOC, S_OUT
   } state_type;

   state_type         state_ff;
   logic [7:0]        count_cfg_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [SOC_W-1:0]  limit_ff;
   logic [4:0]        points_ff;

   logic [8:0]        cnt_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [7:0]        n_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [MV_W-1:0]   mv_ff;
   tab_entry_type     hi_ff;
   logic [PTR_W-1:0]  idx_ff;
   logic [MV_W-1:0]   dv_ff, den_ff;
   logic [PCT_W-1:0]  pd_ff;
   logic              up_ff;
   logic [SOC_W-1:0]  base_ff, soc_ff;
   logic [DIVN_W-1:0] num_calc;

   logic              rsp_valid_ff;
   logic [MV_W-1:0]   rsp_mv_ff;
   logic [SOC_W-1:0]  rsp_soc_ff;
   logic              rsp_low_ff;
   logic              rsp_load;

   tab_entry_type     tab_mem [MAX_POINTS];
   tab_entry_type     rd_data_ff;
   logic [PTR_W-1:0]  rd_addr;

   logic              req_fire;
   logic [7:0]        n_cur;
   logic [8:0]        cnt_next;
   logic [PTR_W:0]    np;
   logic [PTR_W-1:0]  last_idx;
   logic [PTR_W:0]    idx_next;
   logic              div_start, div_done;
   logic [DIVN_W-1:0] div_dividend, div_quo;
   logic [DIVD_W-1:0] div_divisor;
   logic [22:0]       interp_prod;
   logic [SOC_W:0]    soc_calc;
   tab_entry_type     wr_entry;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Effective sample count and table length.
   always_comb begin
      n_cur    = (count_cfg_ff == 8'd0) ? 8'd1 : count_cfg_ff;
      cnt_next = cnt_ff + 9'd1;
      if (points_ff < 5'd2) begin
         np = (PTR_W+1)'(2);
      end else if (points_ff > 5'(MAX_POINTS)) begin
         np = (PTR_W+1)'(MAX_POINTS);
      end else begin
         np = (PTR_W+1)'(points_ff);
      end
      last_idx = PTR_W'(np - 1'b1);
      idx_next = {1'b0, idx_ff} + 1'b1;
   end

   // Table memory address follows the walk state.
   always_comb begin
      case (state_ff)
         S_TAB_LAST: rd_addr = last_idx;
         S_TAB_END:  rd_addr = PTR_W'(1);
         S_TAB_PAIR: rd_addr = idx_next[PTR_W-1:0];
         default:    rd_addr = '0;
      endcase
   end

   // Table memory: written by point transfers, read through a registered port.
   always_comb begin
      wr_entry.mv  = req_point_millivolts;
      wr_entry.pct = (req_point_percent > PCT_MAX) ? PCT_MAX : req_point_percent;
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_mode && ({1'b0, req_point_index} < 5'(MAX_POINTS))) begin
         tab_mem[PTR_W'(req_point_index)] <= wr_entry;
      end
      rd_data_ff <= tab_mem[rd_addr];
   end

   // Divider operand selection; the interpolation numerator is rounded up
   // for a falling segment.
   always_comb begin
      interp_prod  = 23'(dv_ff) * 23'(pd_ff);
      num_calc     = DIVN_W'({interp_prod, 8'd0})
                     + (up_ff ? '0 : DIVN_W'(den_ff - 1'b1));
      div_start    = (state_ff == S_DIV_MV) || (state_ff == S_INTERP);
      div_dividend = (state_ff == S_DIV_MV) ? prod_ff[PROD_W-1:16] : num_calc;
      div_divisor  = (state_ff == S_DIV_MV) ? {8'd0, n_ff} : den_ff;
      if (up_ff) begin
         soc_calc = {1'b0, base_ff} + {1'b0, div_quo[SOC_W-1:0]};
      end else begin
         soc_calc = {1'b0, base_ff} - {1'b0, div_quo[SOC_W-1:0]};
      end
   end

   bse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_cfg_ff <= 8'd10;
         gain_ff      <= 32'd105600;
         limit_ff     <= 15'd5120;
         points_ff    <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: count_cfg_ff <= csr_wdata[7:0];
            CSR_GAIN:         gain_ff      <= csr_wdata;
            CSR_LOW_LIMIT:    limit_ff     <= csr_wdata[SOC_W-1:0];
            CSR_POINTS:       points_ff    <= csr_wdata[4:0];
            default:          ;
         endcase
      end
   end

   // Sequencer for accumulation, scaling, table walk and result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire && !req_mode) begin
                  if (cnt_ff == 9'd0) begin
                     cnt_ff <= 9'd1;
                     sum_ff <= '0;
                  end else begin
                     sum_ff <= sum_ff + SUM_W'(req_adc_code[ADC_BITS-1:0]);
                     cnt_ff <= cnt_next;
                     if (cnt_next > {1'b0, n_cur}) begin
                        n_ff     <= n_cur;
                        state_ff <= S_MUL;
                     end
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(sum_ff) * PROD_W'(gain_ff);
               cnt_ff   <= '0;
               sum_ff   <= '0;
               state_ff <= S_DIV_MV;
            end
            S_DIV_MV: state_ff <= S_WAIT_MV;
            S_WAIT_MV: begin
               if (div_done) begin
                  if (div_quo[DIVN_W-1:MV_W] != '0) begin
                     mv_ff <= '1;
                  end else begin
                     mv_ff <= div_quo[MV_W-1:0];
                  end
                  state_ff <= S_TAB_FIRST;
               end
            end
            S_TAB_FIRST: state_ff <= S_TAB_LAST;
            S_TAB_LAST: begin
               // Entry 0 is on the read port.
               hi_ff <= rd_data_ff;
               if (mv_ff >= rd_data_ff.mv) begin
                  soc_ff   <= SOC_FULL;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_TAB_END;
               end
            end
            S_TAB_END: begin
               // Last entry in use is on the read port.
               idx_ff <= PTR_W'(1);
               if (mv_ff <= rd_data_ff.mv) begin
                  soc_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_TAB_PAIR;
               end
            end
            S_TAB_PAIR: begin
               // Pair of entries idx-1 (held) and idx (read port).
               if ((mv_ff <= hi_ff.mv) && (mv_ff >= rd_data_ff.mv)) begin
                  if (hi_ff.mv == rd_data_ff.mv) begin
                     if (hi_ff.pct < rd_data_ff.pct) begin
                        soc_ff <= {hi_ff.pct, 8'd0};
                     end else begin
                        soc_ff <= {rd_data_ff.pct, 8'd0};
                     end
                     state_ff <= S_OUT;
                  end else begin
                     dv_ff   <= mv_ff - rd_data_ff.mv;
                     den_ff  <= hi_ff.mv - rd_data_ff.mv;
                     base_ff <= {rd_data_ff.pct, 8'd0};
                     up_ff   <= (hi_ff.pct >= rd_data_ff.pct);
                     if (hi_ff.pct >= rd_data_ff.pct) begin
                        pd_ff <= hi_ff.pct - rd_data_ff.pct;
                     end else begin
                        pd_ff <= rd_data_ff.pct - hi_ff.pct;
                     end
                     state_ff <= S_INTERP;
                  end
               end else if (idx_next < np) begin
                  hi_ff  <= rd_data_ff;
                  idx_ff <= idx_next[PTR_W-1:0];
               end else begin
                  soc_ff   <= '0;
                  state_ff <= S_OUT;
               end
            end
            S_INTERP: state_ff <= S_WAIT_SOC;
            S_WAIT_SOC: begin
               if (div_done) begin
                  soc_ff   <= soc_calc[SOC_W-1:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_mv_ff    <= mv_ff;
                  rsp_soc_ff   <= soc_ff;
                  rsp_low_ff   <= (soc_ff < limit_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_battery_millivolts = rsp_mv_ff;
   assign rsp_soc_q8             = rsp_soc_ff;
   assign rsp_battery_low        = rsp_low_ff;
endmodule

FILE: rtl/core/bse_div.sv
// Restoring serial divider, one quotient bit per cycle.
module bse_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bse_pkg::DIVN_W-1:0] dividend,
   input  logic [bse_pkg::DIVD_W-1:0] divisor,
   output logic                       done,
   output logic [bse_pkg::DIVN_W-1:0] quotient
);
   import bse_pkg::*;

   localparam int STEP_W = $clog2(DIVN_W + 1);

   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff, done_ff;
   logic [DIVD_W:0]   rem_sh;
   logic              fits;

   // One trial subtraction per cycle.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVN_W-1]};
      fits   = (rem_sh >= {1'b0, den_ff});
      if (fits) begin
         rem_in = DIVD_W'(rem_sh - {1'b0, den_ff});
      end else begin
         rem_in = rem_sh[DIVD_W-1:0];
      end
      quo_in = {quo_ff[DIVN_W-2:0], fits};
   end

   // Iteration control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DIVN_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
